/* rtl/core/stc_pkg.sv */
// Shared types, codes and constants of the sprite/tile-map collision core.
package stc_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 64;
  localparam int unsigned MAX_ROWS_DEF    = 64;
  localparam int unsigned TILE_BITS_DEF   = 16;

  // Pixel coordinate width: layer origin plus 255 tiles of 255 pixels, with headroom.
  localparam int unsigned COORD_W = 20;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Transform codes at or above this value swap frame width and height.
  localparam logic [2:0] XFORM_SWAP_MIN = 3'd4;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_TEST  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_COLUMNS = 3'd0,
    REG_MAP_ROWS    = 3'd1,
    REG_TILE_WIDTH  = 3'd2,
    REG_TILE_HEIGHT = 3'd3,
    REG_LAYER_LEFT  = 3'd4,
    REG_LAYER_TOP   = 3'd5
  } reg_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [15:0] cell_column;
    logic signed [15:0] cell_row;
    logic signed [15:0] tile_value;
    logic [7:0]         span_columns;
    logic [7:0]         span_rows;
    logic signed [15:0] sprite_left;
    logic signed [15:0] sprite_top;
    logic [11:0]        frame_width;
    logic [11:0]        frame_height;
    logic [2:0]         transform;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic               hit;
  } out_word_t;

  typedef struct packed {
    logic init_step;
    logic accept;
    logic scan_step;
    logic scan_test;
    logic load_read;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic start_empty;
    logic scan_last;
    logic hit;
  } ctrl_stat_t;

endpackage

/* rtl/core/stc_datapath.sv */
// Datapath: configuration registers, tile store, region scanner and overlap test.
module stc_datapath #(
  parameter int unsigned MAX_COLUMNS = stc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = stc_pkg::MAX_ROWS_DEF,
  parameter int unsigned TILE_BITS   = stc_pkg::TILE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  stc_pkg::in_word_t              in_word_i,
  input  stc_pkg::ctrl_cmd_t             cmd_i,
  output stc_pkg::ctrl_stat_t            stat_o,
  output stc_pkg::out_word_t             out_word_o
);
  import stc_pkg::*;

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);

  // configuration
  logic [6:0]         map_columns_q, map_rows_q;
  logic [7:0]         tile_width_q, tile_height_q;
  logic signed [15:0] layer_left_q, layer_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_columns_q <= '0;
      map_rows_q    <= '0;
      tile_width_q  <= '0;
      tile_height_q <= '0;
      layer_left_q  <= '0;
      layer_top_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_MAP_COLUMNS: map_columns_q <= cfg_data_i[6:0];
        REG_MAP_ROWS:    map_rows_q    <= cfg_data_i[6:0];
        REG_TILE_WIDTH:  tile_width_q  <= cfg_data_i[7:0];
        REG_TILE_HEIGHT: tile_height_q <= cfg_data_i[7:0];
        REG_LAYER_LEFT:  layer_left_q  <= $signed(cfg_data_i);
        REG_LAYER_TOP:   layer_top_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic [CW-1:0] cols_used;
  logic [RW-1:0] rows_used;
  assign cols_used = (32'(map_columns_q) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(map_columns_q);
  assign rows_used = (32'(map_rows_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(map_rows_q);

  // single cell addressing
  logic          cell_ok;
  logic [AW-1:0] cell_addr;
  assign cell_ok = !in_word_i.cell_column[15] && !in_word_i.cell_row[15]
                && (in_word_i.cell_column[14:0] < 15'(cols_used))
                && (in_word_i.cell_row[14:0] < 15'(rows_used));
  assign cell_addr = AW'(32'(in_word_i.cell_row[14:0]) * MAX_COLUMNS
                       + 32'(in_word_i.cell_column[14:0]));

  // clear region bounds, clipped to the map in use
  logic signed [17:0] c0_x, r0_x, cs, rs, ce_sum, re_sum, ce, re, cu_x, ru_x;
  logic               clr_empty, test_empty;

  always_comb begin
    c0_x      = 18'(in_word_i.cell_column);
    r0_x      = 18'(in_word_i.cell_row);
    cu_x      = $signed(18'(cols_used));
    ru_x      = $signed(18'(rows_used));
    ce_sum    = c0_x + $signed({10'b0, in_word_i.span_columns});
    re_sum    = r0_x + $signed({10'b0, in_word_i.span_rows});
    ce        = (ce_sum > cu_x) ? cu_x : ce_sum;
    re        = (re_sum > ru_x) ? ru_x : re_sum;
    cs        = c0_x[17] ? '0 : c0_x;
    rs        = r0_x[17] ? '0 : r0_x;
    clr_empty = (cs >= ce) || (rs >= re);
  end

  assign test_empty = (cols_used == '0) || (rows_used == '0)
                   || (tile_width_q == '0) || (tile_height_q == '0);

  // scanner
  logic [CW-1:0]              col_q, col_start_q, col_end_q;
  logic [RW-1:0]              row_q, row_end_q;
  logic signed [COORD_W-1:0]  bx_q, by_q, ax_q, ay_q;
  logic [11:0]                aw_q, ah_q;
  logic                       col_wrap, row_last;
  logic [AW-1:0]              scan_addr;
  logic signed [COORD_W-1:0]  left_x, top_x, tw_x, th_x;
  logic                       swap;

  assign left_x    = COORD_W'(layer_left_q);
  assign top_x     = COORD_W'(layer_top_q);
  assign tw_x      = $signed(COORD_W'(tile_width_q));
  assign th_x      = $signed(COORD_W'(tile_height_q));
  assign swap      = (in_word_i.transform >= XFORM_SWAP_MIN);
  assign col_wrap  = (CW'(col_q + 1'b1) == col_end_q);
  assign row_last  = (RW'(row_q + 1'b1) == row_end_q);
  assign scan_addr = AW'(32'(row_q) * MAX_COLUMNS + 32'(col_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (in_word_i.cmd == CMD_CLEAR) begin
        col_q       <= cs[CW-1:0];
        col_start_q <= cs[CW-1:0];
        col_end_q   <= ce[CW-1:0];
        row_q       <= rs[RW-1:0];
        row_end_q   <= re[RW-1:0];
      end else begin
        col_q       <= '0;
        col_start_q <= '0;
        col_end_q   <= cols_used;
        row_q       <= '0;
        row_end_q   <= rows_used;
      end
      bx_q <= left_x;
      by_q <= top_x;
      ax_q <= COORD_W'(in_word_i.sprite_left);
      ay_q <= COORD_W'(in_word_i.sprite_top);
      aw_q <= swap ? in_word_i.frame_height : in_word_i.frame_width;
      ah_q <= swap ? in_word_i.frame_width : in_word_i.frame_height;
    end else if (cmd_i.scan_step) begin
      if (col_wrap) begin
        col_q <= col_start_q;
        row_q <= RW'(row_q + 1'b1);
        bx_q  <= left_x;
        by_q  <= by_q + th_x;
      end else begin
        col_q <= CW'(col_q + 1'b1);
        bx_q  <= bx_q + tw_x;
      end
    end
  end

  // reset clearing pass counter
  logic [AW-1:0] init_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
    end else if (cmd_i.init_step) begin
      init_cnt_q <= AW'(init_cnt_q + 1'b1);
    end
  end

  // tile store ports
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [TILE_BITS-1:0] mem_wdata, rd_q;
  logic signed [31:0]   tv_x;
  logic [TILE_BITS-1:0] mem [DEPTH];

  assign tv_x = 32'(in_word_i.tile_value);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = init_cnt_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cell_addr;
    if (cmd_i.init_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.accept) begin
      mem_we    = (in_word_i.cmd == CMD_WRITE) && cell_ok;
      mem_waddr = cell_addr;
      mem_wdata = tv_x[TILE_BITS-1:0];
      mem_re    = (in_word_i.cmd == CMD_READ);
    end else if (cmd_i.scan_step) begin
      mem_we    = !cmd_i.scan_test;
      mem_waddr = scan_addr;
      mem_re    = cmd_i.scan_test;
      mem_raddr = scan_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // overlap check in the cycle after the read issue
  logic                      pend_q;
  logic signed [COORD_W-1:0] bx_p_q, by_p_q, aw_x, ah_x;
  logic                      overlap, hit_q, rd_ok_q;
  logic signed [31:0]        rd_x;
  logic signed [15:0]        read_val_q;
  out_word_t                 out_q;

  assign aw_x    = $signed(COORD_W'(aw_q));
  assign ah_x    = $signed(COORD_W'(ah_q));
  assign overlap = (ax_q < bx_p_q + tw_x) && (ax_q + aw_x > bx_p_q)
                && (ay_q < by_p_q + th_x) && (ay_q + ah_x > by_p_q);
  assign rd_x    = 32'($signed(rd_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      pend_q <= cmd_i.scan_step && cmd_i.scan_test;
      if (cmd_i.accept) begin
        hit_q <= 1'b0;
      end else if (pend_q && (rd_q != '0) && overlap) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bx_p_q <= bx_q;
    by_p_q <= by_q;
    if (cmd_i.accept) begin
      rd_ok_q    <= cell_ok;
      read_val_q <= '0;
    end else if (cmd_i.load_read) begin
      read_val_q <= rd_ok_q ? rd_x[15:0] : '0;
    end
    if (cmd_i.load_out) begin
      out_q.read_value <= read_val_q;
      out_q.hit        <= hit_q;
    end
  end

  assign out_word_o         = out_q;
  assign stat_o.init_last   = (init_cnt_q == AW'(DEPTH - 1));
  assign stat_o.start_empty = (in_word_i.cmd == CMD_CLEAR) ? clr_empty : test_empty;
  assign stat_o.scan_last   = col_wrap && row_last;
  assign stat_o.hit         = hit_q;

endmodule

/* rtl/core/stc_ctrl.sv */
// Controller: reset clearing pass, command sequencing and output handshake.
module stc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  stc_pkg::cmd_e       in_cmd_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  stc_pkg::ctrl_stat_t stat_i,
  output stc_pkg::ctrl_cmd_t  cmd_o
);
  import stc_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;
  logic       test_q, test_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    test_d  = test_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    cmd_o.scan_test = test_q;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          test_d = (in_cmd_i == CMD_TEST);
          unique case (in_cmd_i) inside
            CMD_WRITE: state_d = ST_FINISH;
            CMD_READ:  state_d = ST_READ;
            CMD_CLEAR, CMD_TEST: state_d = stat_i.start_empty ? ST_FINISH : ST_SCAN;
            default:   state_d = ST_FINISH;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.load_read = 1'b1;
        state_d = ST_FINISH;
      end
      ST_SCAN: begin
        // a hit ends the test early; reads still in flight cannot undo it
        if (test_q && stat_i.hit) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.scan_last) state_d = test_q ? ST_DRAIN : ST_FINISH;
        end
      end
      ST_DRAIN: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      test_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      test_q      <= test_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/sprite_tilemap_collision_core.sv */
// Sprite against tile-map collision core: tile store with cell, region and collision commands.
// Use: one command word in on the in_* valid/ready channel, one result word out on out_*.
// Configuration (map size, tile size, layer origin) goes through the cfg_* write port,
// to be written by the user only while no command is in progress (the block does not
// enforce this); writes never touch the tile store. After acceptance of a command word a
// cell write goes straight to the finish state and a cell read first loads the read value;
// a region clear and a collision test scan their region row by row, one cell a cycle, the
// test through the single store read port and then through a drain state. A command with
// nothing to scan goes straight to the finish state, and a hit ends the test scan early.
// The finish state moves the result word into the output register once it is free.
// One command is worked on at a time: the next word is taken once the result word has
// been moved into the output register.
// Reset: config registers clear to zero and a clearing pass zeroes the store, one cell a
// cycle, during which no command is taken.
// A stalled receiver holds the result word in the output register; a finished command
// then waits and no new word is accepted until the output register is free.
module sprite_tilemap_collision_core #(
  parameter int unsigned MAX_COLUMNS = stc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = stc_pkg::MAX_ROWS_DEF,
  parameter int unsigned TILE_BITS   = stc_pkg::TILE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  stc_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output stc_pkg::out_word_t             out_word_o
);
  import stc_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  stc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_word_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stc_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .TILE_BITS   (TILE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_word_o  (out_word_o)
  );

endmodule

/* bench/sprite_tilemap_collision_core_tb.sv */
// Self-checking bench for the sprite/tile-map collision core: cell, clear and collision words.
`timescale 1ns / 1ps

module sprite_tilemap_collision_core_tb;
  import stc_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int MAP_COLS      = MAX_COLUMNS_DEF;
  localparam int MAP_ROWS      = MAX_ROWS_DEF;
  localparam int STORE_CELLS   = MAP_COLS * MAP_ROWS;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 200;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  reg_e      cfg_index = REG_MAP_COLUMNS;
  logic [15:0] cfg_data = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t result_word;

  // mirror of the block: tile store and layout registers
  logic [15:0]        tile_mirror [STORE_CELLS];
  logic [6:0]         cfg_cols = '0;
  logic [6:0]         cfg_rows = '0;
  logic [7:0]         cfg_tw   = '0;
  logic [7:0]         cfg_th   = '0;
  logic signed [15:0] cfg_left = '0;
  logic signed [15:0] cfg_top  = '0;

  out_word_t outcome_q [$];
  int        mismatch_count = 0;
  int        words_checked  = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  logic      hold_active    = 1'b0;
  event      hold_off_ev;

  sprite_tilemap_collision_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (result_word)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int cols_in_use();
    return (int'(cfg_cols) > MAP_COLS) ? MAP_COLS : int'(cfg_cols);
  endfunction

  function automatic int rows_in_use();
    return (int'(cfg_rows) > MAP_ROWS) ? MAP_ROWS : int'(cfg_rows);
  endfunction

  function automatic bit cell_addr(input int col, input int row, output int addr);
    addr = 0;
    if (col < 0 || row < 0 || col >= cols_in_use() || row >= rows_in_use()) return 1'b0;
    addr = row * MAP_COLS + col;
    return 1'b1;
  endfunction

  function automatic logic sprite_hits(input in_word_t w);
    longint ax, ay, aw, ah, bx, by, tw, th;
    ax = $signed(w.sprite_left);
    ay = $signed(w.sprite_top);
    if (w.transform >= XFORM_SWAP_MIN) begin
      aw = w.frame_height;
      ah = w.frame_width;
    end else begin
      aw = w.frame_width;
      ah = w.frame_height;
    end
    tw = cfg_tw;
    th = cfg_th;
    if (tw == 0 || th == 0) return 1'b0;
    for (int r = 0; r < rows_in_use(); r++) begin
      for (int c = 0; c < cols_in_use(); c++) begin
        if (tile_mirror[r * MAP_COLS + c] == '0) continue;
        bx = longint'(cfg_left) + c * tw;
        by = longint'(cfg_top) + r * th;
        // strict overlap: a shared edge is no hit
        if (ax < bx + tw && ax + aw > bx && ay < by + th && ay + ah > by) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_word_t apply_tile_cmd(input in_word_t w);
    out_word_t res;
    int addr, col0, row0, col_end, row_end;
    res = '0;
    case (w.cmd)
      CMD_WRITE: begin
        if (cell_addr($signed(w.cell_column), $signed(w.cell_row), addr))
          tile_mirror[addr] = w.tile_value;
      end
      CMD_READ: begin
        if (cell_addr($signed(w.cell_column), $signed(w.cell_row), addr))
          res.read_value = tile_mirror[addr];
      end
      CMD_CLEAR: begin
        col0    = $signed(w.cell_column);
        row0    = $signed(w.cell_row);
        col_end = col0 + int'(w.span_columns);
        row_end = row0 + int'(w.span_rows);
        if (col_end > cols_in_use()) col_end = cols_in_use();
        if (row_end > rows_in_use()) row_end = rows_in_use();
        for (int r = (row0 < 0) ? 0 : row0; r < row_end; r++)
          for (int c = (col0 < 0) ? 0 : col0; c < col_end; c++)
            tile_mirror[r * MAP_COLS + c] = '0;
      end
      default: res.hit = sprite_hits(w);
    endcase
    return res;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    int          reach_x, reach_y;
    w.cell_column  = 16'($urandom);
    w.cell_row     = 16'($urandom);
    w.tile_value   = 16'($urandom);
    w.span_columns = 8'($urandom);
    w.span_rows    = 8'($urandom);
    w.sprite_left  = 16'($urandom);
    w.sprite_top   = 16'($urandom);
    w.frame_width  = 12'($urandom);
    w.frame_height = 12'($urandom);
    w.transform    = 3'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) w.cmd = CMD_WRITE;
    else if (pick < 60) w.cmd = CMD_READ;
    else if (pick < 70) w.cmd = CMD_CLEAR;
    else w.cmd = CMD_TEST;
    // mostly aim at the map in use, one cell past the far edge included
    if ($urandom_range(9) != 0) begin
      w.cell_column = 16'($urandom_range(cols_in_use()));
      w.cell_row    = 16'($urandom_range(rows_in_use()));
    end
    if ($urandom_range(7) != 0) begin
      w.span_columns = 8'($urandom_range(3));
      w.span_rows    = 8'($urandom_range(3));
    end
    if ($urandom_range(7) != 0) begin
      reach_x = cols_in_use() * int'(cfg_tw);
      reach_y = rows_in_use() * int'(cfg_th);
      w.sprite_left  = 16'(int'(cfg_left) + int'($urandom_range(reach_x + 16)) - 8);
      w.sprite_top   = 16'(int'(cfg_top) + int'($urandom_range(reach_y + 16)) - 8);
      w.frame_width  = 12'($urandom_range(2 * int'(cfg_tw) + 2));
      w.frame_height = 12'($urandom_range(2 * int'(cfg_th) + 2));
    end
    return w;
  endfunction

  function automatic in_word_t cell_word(input cmd_e op, input int col, input int row,
                                         input int value);
    in_word_t w;
    w = random_word();
    w.cmd         = op;
    w.cell_column = 16'(col);
    w.cell_row    = 16'(row);
    w.tile_value  = 16'(value);
    return w;
  endfunction

  function automatic in_word_t clear_word(input int col, input int row, input int ncols,
                                          input int nrows);
    in_word_t w;
    w = random_word();
    w.cmd          = CMD_CLEAR;
    w.cell_column  = 16'(col);
    w.cell_row     = 16'(row);
    w.span_columns = 8'(ncols);
    w.span_rows    = 8'(nrows);
    return w;
  endfunction

  function automatic in_word_t sprite_word(input int left, input int top, input int fw,
                                           input int fh, input int xform);
    in_word_t w;
    w = random_word();
    w.cmd          = CMD_TEST;
    w.sprite_left  = 16'(left);
    w.sprite_top   = 16'(top);
    w.frame_width  = 12'(fw);
    w.frame_height = 12'(fh);
    w.transform    = 3'(xform);
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic put_reg(input reg_e idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(value);
    @(posedge clk);
  endtask

  // only called while no command is in progress
  task automatic set_layout(input int cols, input int rows, input int tw, input int th,
                            input int left, input int top);
    put_reg(REG_MAP_COLUMNS, cols);
    put_reg(REG_MAP_ROWS, rows);
    put_reg(REG_TILE_WIDTH, tw);
    put_reg(REG_TILE_HEIGHT, th);
    put_reg(REG_LAYER_LEFT, left);
    put_reg(REG_LAYER_TOP, top);
    cfg_we   <= 1'b0;
    cfg_cols = 7'(cols);
    cfg_rows = 7'(rows);
    cfg_tw   = 8'(tw);
    cfg_th   = 8'(th);
    cfg_left = 16'(left);
    cfg_top  = 16'(top);
  endtask

  task automatic issue_command(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome_q.push_back(apply_tile_cmd(w));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_cell_access();
    set_layout(8, 8, 16, 16, 0, 0);
    issue_command(cell_word(CMD_WRITE, 0, 0, 32767));
    issue_command(cell_word(CMD_WRITE, 7, 7, -32768));
    issue_command(cell_word(CMD_READ, 0, 0, 0));
    issue_command(cell_word(CMD_READ, 7, 7, 0));
    issue_command(cell_word(CMD_WRITE, -1, 3, 5));
    issue_command(cell_word(CMD_WRITE, 8, 0, 9));
    issue_command(cell_word(CMD_READ, 8, 0, 0));
    issue_command(cell_word(CMD_READ, -32768, -1, 0));
    wait_results_drained();
  endtask

  task automatic test_region_clear();
    issue_command(cell_word(CMD_WRITE, 1, 1, 7));
    issue_command(cell_word(CMD_WRITE, 2, 2, -3));
    issue_command(clear_word(-2, -2, 4, 4));   // negative start, clipped
    issue_command(clear_word(7, 7, 0, 0));     // zero span
    issue_command(cell_word(CMD_READ, 7, 7, 0));
    issue_command(clear_word(4, 4, 255, 255)); // runs past the map edge
    issue_command(cell_word(CMD_READ, 1, 1, 0));
    issue_command(cell_word(CMD_READ, 2, 2, 0));
    issue_command(cell_word(CMD_READ, 7, 7, 0));
    wait_results_drained();
  endtask

  // only cell (2,2) is set now: pixels 32..47 on both axes
  task automatic test_collision_edges();
    issue_command(sprite_word(16, 32, 16, 16, 0));
    issue_command(sprite_word(16, 32, 17, 16, 0));
    issue_command(sprite_word(16, 32, 17, 0, 0));
    issue_command(sprite_word(31, 32, 1, 17, 0));
    issue_command(sprite_word(31, 32, 1, 17, 7));
    issue_command(sprite_word(0, 0, 4095, 4095, 5));
    wait_results_drained();
  endtask

  task automatic test_zero_sizes();
    set_layout(8, 8, 0, 255, 0, 0);
    issue_command(sprite_word(0, 0, 4095, 4095, 0));
    wait_results_drained();
    set_layout(0, 0, 1, 1, 32767, 32767);
    issue_command(cell_word(CMD_WRITE, 0, 0, 1));
    issue_command(sprite_word(32767, 32767, 4095, 4095, 4));
    wait_results_drained();
  endtask

  task automatic test_oversized_map();
    // map registers above the store size act as the full store
    set_layout(127, 127, 255, 255, -32768, -32768);
    issue_command(cell_word(CMD_WRITE, 63, 63, 1));
    issue_command(cell_word(CMD_WRITE, 64, 0, 2));
    issue_command(cell_word(CMD_READ, 63, 63, 0));
    issue_command(cell_word(CMD_READ, 0, 1, 0));
    issue_command(sprite_word(-32768 + 63 * 255 + 254, -32768 + 63 * 255 + 254, 1, 1, 0));
    issue_command(sprite_word(32767, 32767, 4095, 4095, 0));
    issue_command(clear_word(0, 0, 255, 255));
    issue_command(cell_word(CMD_READ, 63, 63, 0));
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    set_layout($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 40),
               $urandom_range(1, 40), int'($urandom_range(60000)) - 30000,
               int'($urandom_range(60000)) - 30000);
    repeat (n) issue_command(random_word());
    wait_results_drained();
  endtask

  task automatic test_input_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    -> hold_off_ev;
    repeat (12) issue_command(random_word());
    wait_results_drained();
  endtask

  // long receiver hold-off so that the core fills and stops taking words
  initial forever begin
    @(hold_off_ev);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk)
    out_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing pending", words_checked));
      end else begin
        want = outcome_q.pop_front();
        if (result_word.read_value !== want.read_value)
          report_mismatch($sformatf("word %0d read_value got %0d want %0d", words_checked,
                                    result_word.read_value, want.read_value));
        if (result_word.hit !== want.hit)
          report_mismatch($sformatf("word %0d hit got %b want %b", words_checked,
                                    result_word.hit, want.hit));
      end
    end
  end

  initial begin
    for (int i = 0; i < STORE_CELLS; i++) tile_mirror[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cell_access();
    test_region_clear();
    test_collision_edges();
    test_zero_sizes();
    test_oversized_map();
    test_random_traffic(25, 0, 0);
    test_random_traffic(25, 64, 0);
    test_random_traffic(25, 0, 64);
    test_random_traffic(25, 19, 19);
    test_input_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outcome_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sprite_tilemap_collision_core.f */
rtl/core/stc_pkg.sv
rtl/core/stc_datapath.sv
rtl/core/stc_ctrl.sv
rtl/core/sprite_tilemap_collision_core.sv
bench/sprite_tilemap_collision_core_tb.sv
